>>> sv/lane_segment_steering_estimator_unit_defines.svh
// Assertion macros for the checker file of the lane segment steering estimator.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef LANE_SEGMENT_STEERING_ESTIMATOR_UNIT_DEFINES_SVH
`define LANE_SEGMENT_STEERING_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lsse_pkg.sv
// Shared types, widths, codes and the CORDIC arctangent table of the estimator.
// Depends on nothing; every module imports it.
package lsse_pkg;

  localparam int COORD_BITS   = 12;
  localparam int MAX_SEGMENTS = 1024;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CORD_N       = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int STEP_W       = $clog2(TAB_LEN);

  localparam int FW_W = 12;
  localparam int RA_W = 7;
  localparam int DR_W = 4;

  localparam int DELTA_W = COORD_BITS + 1;
  localparam int MID_W   = COORD_BITS;
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int MSUM_W  = MID_W + CNT_W;
  localparam int ANG_W   = 17;
  localparam int ASUM_W  = ANG_W + CNT_W - 1;
  localparam int CORD_W  = COORD_BITS + 12;
  localparam int Z_W     = 25;

  localparam int NPROD_W  = MSUM_W + CNT_W + 1;
  localparam int DPROD_W  = 2 * CNT_W;
  localparam int DIV_N_W  = NPROD_W + 5;
  localparam int DIV_D_W  = DPROD_W + 1;
  localparam int DIV_C_W  = $clog2(DIV_N_W + 1);

  localparam int ANG_90_I  = 23040;
  localparam int ANG_180_I = 46080;

  // Division by seven as a multiply by ceil(2^17 / 7) and a shift by 17; exact for
  // every dividend below 43690, which covers six times the widest frame.
  localparam int SIDE_W     = FW_W + 3;
  localparam int SIDE_RECIP = 18725;
  localparam int SIDE_SHIFT = 17;

  typedef enum logic [1:0] {
    DEC_BOTH  = 2'd0,
    DEC_LEFT  = 2'd1,
    DEC_RIGHT = 2'd2,
    DEC_NONE  = 2'd3
  } dec_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH = 2'd0,
    REG_REJECT      = 2'd1,
    REG_RATIO       = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                       has_seg;
    logic                       zero_len;
    logic                       fe;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
    logic [MID_W-1:0]           mid;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/lsse_front.sv
// Front end: accepts input transactions, classifies them and holds them in a two-entry queue.
// Depends on lsse_pkg.
module lsse_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           has_segment,
  input  logic [lsse_pkg::COORD_BITS-1:0] start_x,
  input  logic [lsse_pkg::COORD_BITS-1:0] start_y,
  input  logic [lsse_pkg::COORD_BITS-1:0] end_x,
  input  logic [lsse_pkg::COORD_BITS-1:0] end_y,
  input  logic                           frame_end,
  output lsse_pkg::qhead_t               head,
  input  logic                           pop
);
  import lsse_pkg::*;

  item_t             mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              do_pop;
  item_t             cls;
  logic [COORD_BITS:0] mid_sum;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count != 2'd0);

  always_comb begin
    mid_sum      = {1'b0, start_x} + {1'b0, end_x};
    cls.has_seg  = has_segment;
    cls.fe       = frame_end;
    cls.dx       = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    cls.dy       = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    cls.zero_len = (end_x == start_x) && (end_y == start_y);
    cls.mid      = mid_sum[COORD_BITS:1];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = mem[rd_ptr];

endmodule

>>> sv/lsse_div.sv
// Restoring divider, one quotient bit per cycle, shared by all end-of-frame divisions.
// Depends on lsse_pkg.
module lsse_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lsse_pkg::DIV_N_W-1:0]  dividend,
  input  logic [lsse_pkg::DIV_D_W-1:0]  divisor,
  output logic                          done,
  output logic [lsse_pkg::DIV_N_W-1:0]  quotient
);
  import lsse_pkg::*;

  logic                 running;
  logic [DIV_C_W-1:0]   cnt;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dvs;
  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  assign trial    = {rem, quo[DIV_N_W-1]};
  assign fits     = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_C_W'(DIV_N_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      rem <= fits ? DIV_D_W'(trial - {1'b0, dvs}) : trial[DIV_D_W-1:0];
      quo <= {quo[DIV_N_W-2:0], fits};
    end
  end

endmodule

>>> sv/lsse_back.sv
// Back end: CORDIC angle, side accumulation and the end-of-frame decision sequencer.
// Depends on lsse_pkg and lsse_div.
module lsse_back (
  input  logic                      clk,
  input  logic                      rst,
  input  lsse_pkg::qhead_t          head,
  output logic                      pop,
  input  logic [lsse_pkg::FW_W-1:0] frame_width,
  input  logic [lsse_pkg::RA_W-1:0] reject_angle,
  input  logic [lsse_pkg::DR_W-1:0] dominance_ratio,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [15:0]               steering_angle,
  output logic [15:0]               center_x,
  output logic [1:0]                decision
);
  import lsse_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CORD   = 13'b0000000000010,
    S_RND    = 13'b0000000000100,
    S_ACC    = 13'b0000000001000,
    S_FRAME  = 13'b0000000010000,
    S_MEAN1  = 13'b0000000100000,
    S_MEAN2  = 13'b0000001000000,
    S_MULA   = 13'b0000010000000,
    S_MULB   = 13'b0000100000000,
    S_MULC   = 13'b0001000000000,
    S_CSTART = 13'b0010000000000,
    S_CDIV   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state;

  logic signed [CORD_W-1:0]  x, y, xs, ys;
  logic signed [Z_W-1:0]     z, tab_val, z_bias, z_sh;
  logic signed [ANG_W-1:0]   off;
  logic [STEP_W-1:0]         step;
  logic signed [ANG_W-1:0]   a;
  logic signed [ANG_W:0]     ang_raw;
  logic                      fe;
  logic [MID_W-1:0]          mid;

  logic signed [ASUM_W-1:0]  lsum, rsum;
  logic [MSUM_W-1:0]         lmsum, rmsum;
  logic [CNT_W-1:0]          lc, rc;

  logic signed [DELTA_W-1:0] ux, uy;
  logic [ANG_W-1:0]          a_mag;
  logic [FW_W-2:0]           half;
  logic [CNT_W+DR_W-1:0]     lc_scaled, rc_scaled;
  dec_t                      dec, dec_next;
  logic [ASUM_W-1:0]         lmag, rmag;
  logic [15:0]               mean1, mean_now;
  logic [16:0]               mean_sum;
  logic [MSUM_W+CNT_W-1:0]   prod_l, prod_r;
  logic [NPROD_W-1:0]        nprod;
  logic [DPROD_W-1:0]        dprod;
  logic [SIDE_W-1:0]         side_num;
  logic [2*SIDE_W-1:0]       side_prod;
  logic [15:0]               angle, center;
  logic                      out_load;

  logic                      div_start, div_done;
  logic [DIV_N_W-1:0]        div_dvd, div_q;
  logic [DIV_D_W-1:0]        div_dvs;

  lsse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Fold a rounded side mean into 0..180 degrees.
  function automatic logic [15:0] fold(input logic [DIV_N_W-1:0] q, input logic neg);
    logic [15:0] m;
    m = q[15:0];
    if (neg && (m != 16'd0)) begin
      m = 16'(ANG_180_I) - m;
    end
    return m;
  endfunction

  // A signed delta scaled by 256 and sign-extended to the CORDIC width.
  function automatic logic signed [CORD_W-1:0] scale8(input logic signed [DELTA_W-1:0] v);
    return {{(CORD_W-DELTA_W-8){v[DELTA_W-1]}}, v, 8'h00};
  endfunction

  always_comb begin
    xs       = x >>> step;
    ys       = y >>> step;
    tab_val  = atan_entry(step);
    z_bias   = z + Z_W'(128);
    z_sh     = z_bias >>> 8;
    ang_raw  = $signed(z_sh[ANG_W:0]) + {off[ANG_W-1], off};
    ux       = -head.item.dy;
    uy       = -head.item.dx;
    a_mag    = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
    half     = frame_width[FW_W-1:1];
    lc_scaled = lc * dominance_ratio;
    rc_scaled = rc * dominance_ratio;
    lmag     = lsum[ASUM_W-1] ? ASUM_W'(-lsum) : ASUM_W'(lsum);
    rmag     = rsum[ASUM_W-1] ? ASUM_W'(-rsum) : ASUM_W'(rsum);
    prod_l   = lmsum * rc;
    prod_r   = rmsum * lc;
    out_load = (state == S_OUT) && (!out_valid || !out_stall);
    pop      = (state == S_IDLE) && head.valid;

    // Fallback center of a dominant side: width/7 or width*6/7 by reciprocal multiply.
    side_num  = (dec == DEC_RIGHT) ?
                ((SIDE_W'(frame_width) << 2) + (SIDE_W'(frame_width) << 1)) :
                SIDE_W'(frame_width);
    side_prod = side_num * SIDE_W'(SIDE_RECIP);

    if ((CNT_W+DR_W)'(lc) > rc_scaled) begin
      dec_next = DEC_LEFT;
    end else if ((CNT_W+DR_W)'(rc) > lc_scaled) begin
      dec_next = DEC_RIGHT;
    end else if ((lc == '0) || (rc == '0)) begin
      dec_next = DEC_NONE;
    end else begin
      dec_next = DEC_BOTH;
    end

    mean_now = fold(div_q, (dec == DEC_RIGHT) ? rsum[ASUM_W-1] : lsum[ASUM_W-1]);
    mean_sum = {1'b0, mean1} + {1'b0, fold(div_q, rsum[ASUM_W-1])} + 17'd1;

    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = DIV_D_W'(1);
    unique case (state)
      S_FRAME: begin
        if (dec_next == DEC_RIGHT) begin
          div_start = 1'b1;
          div_dvd   = DIV_N_W'(rmag) + DIV_N_W'(rc >> 1);
          div_dvs   = DIV_D_W'(rc);
        end else if (dec_next != DEC_NONE) begin
          div_start = 1'b1;
          div_dvd   = DIV_N_W'(lmag) + DIV_N_W'(lc >> 1);
          div_dvs   = DIV_D_W'(lc);
        end
      end
      S_MEAN1: begin
        if (div_done && (dec == DEC_BOTH)) begin
          div_start = 1'b1;
          div_dvd   = DIV_N_W'(rmag) + DIV_N_W'(rc >> 1);
          div_dvs   = DIV_D_W'(rc);
        end
      end
      S_CSTART: begin
        div_start = 1'b1;
        div_dvd   = DIV_N_W'({nprod, 4'b0000}) + DIV_N_W'(dprod);
        div_dvs   = {dprod, 1'b0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      lsum      <= '0;
      rsum      <= '0;
      lmsum     <= '0;
      rmsum     <= '0;
      lc        <= '0;
      rc        <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            if (head.item.has_seg && !head.item.zero_len) begin
              state <= S_CORD;
            end else if (head.item.fe) begin
              state <= S_FRAME;
            end
          end
        end
        S_CORD: begin
          if (step == STEP_W'(CORD_N - 1)) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (a_mag > ANG_W'({reject_angle, 8'h00})) begin
            if ({1'b0, half} > mid) begin
              if (lc < CNT_W'(MAX_SEGMENTS)) begin
                lsum  <= lsum + ASUM_W'(a);
                lmsum <= lmsum + MSUM_W'(mid);
                lc    <= lc + 1'b1;
              end
            end else if (mid > {1'b0, half}) begin
              if (rc < CNT_W'(MAX_SEGMENTS)) begin
                rsum  <= rsum + ASUM_W'(a);
                rmsum <= rmsum + MSUM_W'(mid);
                rc    <= rc + 1'b1;
              end
            end
          end
          state <= fe ? S_FRAME : S_IDLE;
        end
        S_FRAME: begin
          state <= (dec_next == DEC_NONE) ? S_OUT : S_MEAN1;
        end
        S_MEAN1: begin
          if (div_done) begin
            state <= (dec == DEC_BOTH) ? S_MEAN2 : S_OUT;
          end
        end
        S_MEAN2: begin
          if (div_done) begin
            state <= S_MULA;
          end
        end
        S_MULA: begin
          state <= S_MULB;
        end
        S_MULB: begin
          state <= S_MULC;
        end
        S_MULC: begin
          state <= S_CSTART;
        end
        S_CSTART: begin
          state <= S_CDIV;
        end
        S_CDIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
            lsum  <= '0;
            rsum  <= '0;
            lmsum <= '0;
            rmsum <= '0;
            lc    <= '0;
            rc    <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        fe   <= head.item.fe;
        mid  <= head.item.mid;
        step <= '0;
        z    <= '0;
        if (head.item.dx[DELTA_W-1]) begin
          if (!head.item.dy[DELTA_W-1]) begin
            x   <= scale8(head.item.dy);
            y   <= scale8(uy);
            off <= ANG_W'(ANG_90_I);
          end else begin
            x   <= scale8(ux);
            y   <= scale8(head.item.dx);
            off <= -ANG_W'(ANG_90_I);
          end
        end else begin
          x   <= scale8(head.item.dx);
          y   <= scale8(head.item.dy);
          off <= '0;
        end
      end
      S_CORD: begin
        step <= step + 1'b1;
        if (!y[CORD_W-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tab_val;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tab_val;
        end
      end
      S_RND: begin
        if (ang_raw > (ANG_W+1)'(ANG_180_I)) begin
          a <= ANG_W'(ANG_180_I);
        end else if (ang_raw < -(ANG_W+1)'(ANG_180_I)) begin
          a <= -ANG_W'(ANG_180_I);
        end else begin
          a <= ang_raw[ANG_W-1:0];
        end
      end
      S_FRAME: begin
        dec <= dec_next;
        if (dec_next == DEC_NONE) begin
          angle  <= 16'(ANG_90_I);
          center <= 16'({half, 4'b0000});
        end
      end
      S_MEAN1: begin
        if (div_done) begin
          mean1 <= mean_now;
          angle <= mean_now;
          if (dec != DEC_BOTH) begin
            center <= {side_prod[SIDE_SHIFT+FW_W-1:SIDE_SHIFT], 4'b0000};
          end
        end
      end
      S_MEAN2: begin
        if (div_done) begin
          angle <= mean_sum[16:1];
        end
      end
      S_MULA: begin
        nprod <= NPROD_W'(prod_l);
      end
      S_MULB: begin
        nprod <= nprod + NPROD_W'(prod_r);
      end
      S_MULC: begin
        dprod <= lc * rc;
      end
      S_CDIV: begin
        if (div_done) begin
          center <= (|div_q[DIV_N_W-1:16]) ? 16'hFFFF : div_q[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      steering_angle <= angle;
      center_x       <= center;
      decision       <= dec;
    end
  end

endmodule

>>> sv/lane_segment_steering_estimator_unit.sv
// Top level of the lane segment steering estimator: configuration registers and the
// front/back split. Depends on lsse_pkg, lsse_front, lsse_back and lsse_div.
//
// The block takes the line segments of a frame one transaction at a time, measures
// each segment's angle with a 16-step CORDIC, sorts kept segments to the left or right
// half of the frame, and on the transaction that carries frame_end emits one result:
// steering angle (Q8.8 degrees, 0 to 180), lane center (Q12.4 pixels) and a decision
// code. The back end takes a segment transaction from the queue, runs the CORDIC
// iterations, rounds the angle and accumulates it if the segment is kept; a transaction
// without a segment, or with a zero-length one, skips these steps. At frame end the
// sequencer runs serial divisions on one shared divider: a mean division when one side
// dominates (its fallback center comes from a multiply by the reciprocal of seven), a
// mean division per side and a center division when both sides are averaged, and none
// when no lane is found. A two-entry queue sits between input and back end, and the
// result sits in an output register, so the next frame proceeds while it waits.
module lane_segment_steering_estimator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            has_segment,
  input  logic [lsse_pkg::COORD_BITS-1:0] start_x,
  input  logic [lsse_pkg::COORD_BITS-1:0] start_y,
  input  logic [lsse_pkg::COORD_BITS-1:0] end_x,
  input  logic [lsse_pkg::COORD_BITS-1:0] end_y,
  input  logic                            frame_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     steering_angle,
  output logic [15:0]                     center_x,
  output logic [1:0]                      decision
);
  import lsse_pkg::*;

  logic [FW_W-1:0] frame_width;
  logic [RA_W-1:0] reject_angle;
  logic [DR_W-1:0] dominance_ratio;
  logic            cfg_wr;
  qhead_t          head;
  logic            pop;

  // The register port never waits; a write completes on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= FW_W'(640);
      reject_angle    <= RA_W'(10);
      dominance_ratio <= DR_W'(3);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FRAME_WIDTH: frame_width     <= pwdata[FW_W-1:0];
        REG_REJECT:      reject_angle    <= pwdata[RA_W-1:0];
        REG_RATIO:       dominance_ratio <= pwdata[DR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Reads return the register value, zero-extended; an unused address reads zero.
  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH: prdata = 32'(frame_width);
      REG_REJECT:      prdata = 32'(reject_angle);
      REG_RATIO:       prdata = 32'(dominance_ratio);
      default:         prdata = '0;
    endcase
  end

  // The front end computes the deltas and midpoint of each transaction and queues it.
  lsse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .has_segment (has_segment),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .frame_end   (frame_end),
    .head        (head),
    .pop         (pop)
  );

  // The back end runs the CORDIC, the side sums and the end-of-frame decision.
  lsse_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .frame_width     (frame_width),
    .reject_angle    (reject_angle),
    .dominance_ratio (dominance_ratio),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .steering_angle  (steering_angle),
    .center_x        (center_x),
    .decision        (decision)
  );

endmodule

>>> sv/lsse_checker.sv
// Port-level checks of the estimator's result channel and register port, bound to the top.
// Depends on lsse_pkg and the assertion macros header.
`include "lane_segment_steering_estimator_unit_defines.svh"

module lsse_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] steering_angle,
  input logic [15:0] center_x,
  input logic [1:0]  decision
);
  import lsse_pkg::*;

  `LSSE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(steering_angle) && $stable(center_x) && $stable(decision), "result changed while stalled")
  `LSSE_ASSERT_IMP(a_angle_range, out_valid, steering_angle <= 16'(ANG_180_I), "steering angle above 180 degrees")
  `LSSE_ASSERT_IMP(a_none_angle, out_valid && (decision == DEC_NONE), steering_angle == 16'(ANG_90_I), "no-lane result without 90 degrees")
  `LSSE_ASSERT_IMP(a_side_center, out_valid && (decision != DEC_BOTH), center_x[3:0] == 4'd0, "fallback center not whole pixels")
  `LSSE_ASSERT_IMP(a_pready, 1'b1, pready, "register port not ready")

endmodule

bind lane_segment_steering_estimator_unit lsse_checker u_lsse_checker (.*);
